### rtl/dmx_pkg.sv
// package for the stereo downmix: widths, gain constants, config and lane types
package dmx_pkg;

    localparam int SAMPLE_BITS = 24;
    localparam int FRAC_BITS   = 16;
    localparam int GAIN_W      = FRAC_BITS + 1;
    localparam int OP_W        = SAMPLE_BITS + 2;
    localparam int PROD_W      = OP_W + GAIN_W + 1;
    localparam int ACC_W       = PROD_W + 2;
    localparam int Q_W         = ACC_W - FRAC_BITS;
    localparam int NUM_LANES   = 6;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 3;

    // lane positions: three per output side
    localparam int LANE_L_FRONT  = 0;
    localparam int LANE_L_CENTRE = 1;
    localparam int LANE_L_SUR    = 2;
    localparam int LANE_R_FRONT  = 3;
    localparam int LANE_R_CENTRE = 4;
    localparam int LANE_R_SUR    = 5;

    // Q16 gains
    localparam logic [GAIN_W-1:0] G_UNITY        = GAIN_W'(1 << FRAC_BITS);
    localparam logic [GAIN_W-1:0] G_MATRIX_SUR   = GAIN_W'(14844);
    localparam logic [GAIN_W-1:0] G_MATRIX_FRONT = GAIN_W'(20998);
    localparam logic [GAIN_W-1:0] G_MATRIX_CTR   = GAIN_W'(14844);
    localparam logic [GAIN_W-1:0] G_PLAIN_FRONT  = GAIN_W'(27145);
    localparam logic [GAIN_W-1:0] G_MONO         = GAIN_W'(46341);

    localparam logic [GAIN_W-1:0] CENTRE_GAIN [4] = '{
        GAIN_W'(19189), GAIN_W'(16174), GAIN_W'(13573), GAIN_W'(16174)
    };
    localparam logic [GAIN_W-1:0] SURROUND_GAIN [4] = '{
        GAIN_W'(19189), GAIN_W'(13573), GAIN_W'(0), GAIN_W'(13573)
    };

    typedef enum logic [2:0] {
        LAYOUT_DUAL_MONO,
        LAYOUT_MONO,
        LAYOUT_STEREO,
        LAYOUT_3_0,
        LAYOUT_2_1,
        LAYOUT_3_1,
        LAYOUT_2_2,
        LAYOUT_3_2
    } layout_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CHANNEL_LAYOUT,
        CFG_MATRIX_SURROUND_ON,
        CFG_CENTER_LEVEL_CODE,
        CFG_SURROUND_LEVEL_CODE,
        CFG_DUAL_MONO_PICK
    } cfg_index_t;

    typedef struct packed {
        layout_t    layout;
        logic       matrix_on;
        logic [1:0] center_code;
        logic [1:0] surround_code;
        logic       dual_pick;
    } cfg_t;

    typedef struct packed {
        logic signed [OP_W-1:0] op;
        logic [GAIN_W-1:0]      gain;
    } lane_op_t;

    typedef lane_op_t [NUM_LANES-1:0] lane_ops_t;
    typedef logic signed [NUM_LANES-1:0][PROD_W-1:0] lane_prods_t;

endpackage

### rtl/dmx_in_if.sv
// input channel: one sample slot of up to five channel samples
interface dmx_in_if import dmx_pkg::*; ();
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] sample_slot0;
    logic signed [SAMPLE_BITS-1:0] sample_slot1;
    logic signed [SAMPLE_BITS-1:0] sample_slot2;
    logic signed [SAMPLE_BITS-1:0] sample_slot3;
    logic signed [SAMPLE_BITS-1:0] sample_slot4;

    modport source (
        output valid, sample_slot0, sample_slot1, sample_slot2, sample_slot3, sample_slot4,
        input  ready
    );
    modport sink (
        input  valid, sample_slot0, sample_slot1, sample_slot2, sample_slot3, sample_slot4,
        output ready
    );
endinterface

### rtl/dmx_out_if.sv
// output channel: one stereo pair
interface dmx_out_if import dmx_pkg::*; ();
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] mix_left;
    logic signed [SAMPLE_BITS-1:0] mix_right;

    modport source (output valid, mix_left, mix_right, input ready);
    modport sink (input valid, mix_left, mix_right, output ready);
endinterface

### rtl/dmx_route.sv
// routes slot samples and gains to the six multiply lanes per layout and mode
module dmx_route import dmx_pkg::*; (
    input  logic                          clk,
    input  logic                          en,
    input  cfg_t                          cfg,
    input  logic signed [SAMPLE_BITS-1:0] slot0,
    input  logic signed [SAMPLE_BITS-1:0] slot1,
    input  logic signed [SAMPLE_BITS-1:0] slot2,
    input  logic signed [SAMPLE_BITS-1:0] slot3,
    input  logic signed [SAMPLE_BITS-1:0] slot4,
    output lane_ops_t                     lanes
);

    logic signed [OP_W-1:0] s0, s1, s2, s3, s4;
    logic signed [OP_W-1:0] sur_l, sur_r;
    logic [GAIN_W-1:0]      front_gain, centre_gain, sur_gain;
    lane_ops_t              lanes_next;
    lane_ops_t              lanes_reg;

    assign s0 = OP_W'(slot0);
    assign s1 = OP_W'(slot1);
    assign s2 = OP_W'(slot2);
    assign s3 = OP_W'(slot3);
    assign s4 = OP_W'(slot4);

    always_comb
    begin
        lanes_next  = '0;
        sur_l       = '0;
        sur_r       = '0;
        front_gain  = cfg.matrix_on ? G_MATRIX_FRONT : G_PLAIN_FRONT;
        centre_gain = cfg.matrix_on ? G_MATRIX_CTR : CENTRE_GAIN[cfg.center_code];
        sur_gain    = cfg.matrix_on ? G_MATRIX_SUR : SURROUND_GAIN[cfg.surround_code];

        // surround operands; matrix mode pre-sums the pair since both share one gain
        case (cfg.layout)
            LAYOUT_2_1:
            begin
                sur_l = s2;
                sur_r = s2;
            end
            LAYOUT_3_1:
            begin
                sur_l = s3;
                sur_r = s3;
            end
            LAYOUT_2_2:
            begin
                sur_l = cfg.matrix_on ? s2 + s3 : s2;
                sur_r = cfg.matrix_on ? s2 + s3 : s3;
            end
            LAYOUT_3_2:
            begin
                sur_l = cfg.matrix_on ? s3 + s4 : s3;
                sur_r = cfg.matrix_on ? s3 + s4 : s4;
            end
            default:
            begin
                sur_l = '0;
                sur_r = '0;
            end
        endcase

        case (cfg.layout)
            LAYOUT_STEREO:
            begin
                lanes_next[LANE_L_FRONT] = '{op: s0, gain: G_UNITY};
                lanes_next[LANE_R_FRONT] = '{op: s1, gain: G_UNITY};
            end
            LAYOUT_MONO:
            begin
                lanes_next[LANE_L_FRONT] = '{op: s0, gain: G_MONO};
                lanes_next[LANE_R_FRONT] = '{op: s0, gain: G_MONO};
            end
            LAYOUT_DUAL_MONO:
            begin
                lanes_next[LANE_L_FRONT] = '{op: (cfg.dual_pick ? s1 : s0), gain: G_MONO};
                lanes_next[LANE_R_FRONT] = '{op: (cfg.dual_pick ? s1 : s0), gain: G_MONO};
            end
            default:
            begin
                lanes_next[LANE_L_FRONT] = '{op: s0, gain: front_gain};
                if (cfg.layout inside {LAYOUT_3_0, LAYOUT_3_1, LAYOUT_3_2})
                begin
                    lanes_next[LANE_R_FRONT]  = '{op: s2, gain: front_gain};
                    lanes_next[LANE_L_CENTRE] = '{op: s1, gain: centre_gain};
                    lanes_next[LANE_R_CENTRE] = '{op: s1, gain: centre_gain};
                end
                else
                begin
                    lanes_next[LANE_R_FRONT] = '{op: s1, gain: front_gain};
                end
                if (cfg.layout != LAYOUT_3_0)
                begin
                    // matrix surround feeds left negated
                    lanes_next[LANE_L_SUR] = '{op: (cfg.matrix_on ? -sur_l : sur_l),
                                               gain: sur_gain};
                    lanes_next[LANE_R_SUR] = '{op: sur_r, gain: sur_gain};
                end
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            lanes_reg <= lanes_next;
        end
    end

    assign lanes = lanes_reg;

endmodule

### rtl/dmx_lane.sv
// one multiply lane: signed operand times unsigned Q16 gain, registered
module dmx_lane import dmx_pkg::*; (
    input  logic                     clk,
    input  logic                     en,
    input  lane_op_t                 lane_in,
    output logic signed [PROD_W-1:0] prod
);

    logic signed [PROD_W-1:0] prod_reg;
    logic signed [PROD_W-1:0] prod_next;

    assign prod_next = PROD_W'(lane_in.op * $signed({1'b0, lane_in.gain}));

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg <= prod_next;
        end
    end

    assign prod = prod_reg;

endmodule

### rtl/dmx_merge.sv
// sums the lane products per side, rounds half up and saturates
module dmx_merge import dmx_pkg::*; (
    input  logic                          clk,
    input  logic                          en,
    input  lane_prods_t                   prods,
    output logic signed [SAMPLE_BITS-1:0] mix_left,
    output logic signed [SAMPLE_BITS-1:0] mix_right
);

    localparam logic signed [ACC_W-1:0] ROUND_HALF = ACC_W'(1 << (FRAC_BITS - 1));
    localparam logic signed [Q_W-1:0]   S_MAX = Q_W'((64'sd1 <<< (SAMPLE_BITS - 1)) - 1);
    localparam logic signed [Q_W-1:0]   S_MIN = Q_W'(-(64'sd1 <<< (SAMPLE_BITS - 1)));

    logic signed [ACC_W-1:0]       acc_l, acc_r;
    logic signed [Q_W-1:0]         q_l, q_r;
    logic signed [SAMPLE_BITS-1:0] left_next, right_next;
    logic signed [SAMPLE_BITS-1:0] left_reg, right_reg;

    function automatic logic signed [SAMPLE_BITS-1:0] sat(input logic signed [Q_W-1:0] q);
        logic signed [SAMPLE_BITS-1:0] r;
        if (q > S_MAX)
            r = S_MAX[SAMPLE_BITS-1:0];
        else if (q < S_MIN)
            r = S_MIN[SAMPLE_BITS-1:0];
        else
            r = q[SAMPLE_BITS-1:0];
        return r;
    endfunction

    always_comb
    begin
        // elements of a packed array select as unsigned, so sign them before extending
        acc_l = ACC_W'($signed(prods[LANE_L_FRONT])) + ACC_W'($signed(prods[LANE_L_CENTRE]))
              + ACC_W'($signed(prods[LANE_L_SUR])) + ROUND_HALF;
        acc_r = ACC_W'($signed(prods[LANE_R_FRONT])) + ACC_W'($signed(prods[LANE_R_CENTRE]))
              + ACC_W'($signed(prods[LANE_R_SUR])) + ROUND_HALF;
        // arithmetic shift gives the floor
        q_l        = Q_W'(acc_l >>> FRAC_BITS);
        q_r        = Q_W'(acc_r >>> FRAC_BITS);
        left_next  = sat(q_l);
        right_next = sat(q_r);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            left_reg  <= left_next;
            right_reg <= right_next;
        end
    end

    assign mix_left  = left_reg;
    assign mix_right = right_reg;

endmodule

### rtl/multichannel_to_stereo_downmix_unit.sv
// an input transfer passes the route, multiply and merge registers on its way to its result
// throughput: one slot per cycle; each of the three stages holds its item while the next
// stage is full, so input keeps flowing into empty stages while a result waits
// six multiply lanes, one per product term, set the per-cycle work
// reset: rst_n clears the stage valids and returns config to layout 2/0, plain mode, codes 0
module multichannel_to_stereo_downmix_unit import dmx_pkg::*; (
    input  logic                  clk,
    input  logic                  rst_n,
    dmx_in_if.sink                slot_in,
    dmx_out_if.source             mix_out,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata
);

    cfg_t        cfg_reg;
    logic        route_valid_reg, prod_valid_reg, out_valid_reg;
    logic        en_route, en_prod, en_out;
    lane_ops_t   lanes;
    lane_prods_t prods;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '{layout: LAYOUT_STEREO, matrix_on: 1'b0, center_code: 2'd0,
                         surround_code: 2'd0, dual_pick: 1'b0};
        end
        else if (cfg_wr_en)
        begin
            case (cfg_addr)
                CFG_CHANNEL_LAYOUT:      cfg_reg.layout        <= layout_t'(cfg_wdata[2:0]);
                CFG_MATRIX_SURROUND_ON:  cfg_reg.matrix_on     <= cfg_wdata[0];
                CFG_CENTER_LEVEL_CODE:   cfg_reg.center_code   <= cfg_wdata[1:0];
                CFG_SURROUND_LEVEL_CODE: cfg_reg.surround_code <= cfg_wdata[1:0];
                CFG_DUAL_MONO_PICK:      cfg_reg.dual_pick     <= cfg_wdata[0];
                default:                 cfg_reg               <= cfg_reg;
            endcase
        end
    end

    // a stage loads when it is empty or its contents move on
    assign en_out   = !out_valid_reg || mix_out.ready;
    assign en_prod  = !prod_valid_reg || en_out;
    assign en_route = !route_valid_reg || en_prod;

    assign slot_in.ready = en_route;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            route_valid_reg <= 1'b0;
            prod_valid_reg  <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (en_route)
                route_valid_reg <= slot_in.valid;
            if (en_prod)
                prod_valid_reg <= route_valid_reg;
            if (en_out)
                out_valid_reg <= prod_valid_reg;
        end
    end

    dmx_route u_route (
        .clk   (clk),
        .en    (en_route),
        .cfg   (cfg_reg),
        .slot0 (slot_in.sample_slot0),
        .slot1 (slot_in.sample_slot1),
        .slot2 (slot_in.sample_slot2),
        .slot3 (slot_in.sample_slot3),
        .slot4 (slot_in.sample_slot4),
        .lanes (lanes)
    );

    for (genvar i = 0; i < NUM_LANES; i++)
    begin : g_lane
        dmx_lane u_lane (
            .clk     (clk),
            .en      (en_prod),
            .lane_in (lanes[i]),
            .prod    (prods[i])
        );
    end

    dmx_merge u_merge (
        .clk       (clk),
        .en        (en_out),
        .prods     (prods),
        .mix_left  (mix_out.mix_left),
        .mix_right (mix_out.mix_right)
    );

    assign mix_out.valid = out_valid_reg;

endmodule

### rtl/dmx_checker.sv
// port-level checks for the downmix unit, bound to the top level
module dmx_checker import dmx_pkg::*; (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          in_valid,
    input logic                          in_ready,
    input logic                          out_valid,
    input logic                          out_ready,
    input logic signed [SAMPLE_BITS-1:0] out_left,
    input logic signed [SAMPLE_BITS-1:0] out_right
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_left) && $stable(out_right))
        else $error("result changed while stalled");

    // with no result pending the pipeline must take input
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input not ready with empty output");

    // a transfer reaches the output through the route, multiply and merge registers when the sink keeps up
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) ##1 out_ready ##1 out_ready |=> out_valid)
        else $error("result late");

    // nothing comes out right after reset
    a_reset_empty: assert property (@(posedge clk)
        $rose(rst_n) |-> !out_valid)
        else $error("result valid after reset");

endmodule

bind multichannel_to_stereo_downmix_unit dmx_checker u_dmx_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (slot_in.valid),
    .in_ready  (slot_in.ready),
    .out_valid (mix_out.valid),
    .out_ready (mix_out.ready),
    .out_left  (mix_out.mix_left),
    .out_right (mix_out.mix_right)
);

### sim/tb.sv
// testbench for the stereo downmix unit: random and directed slots checked against a predictor
`timescale 1ns / 100ps

module tb;
    import dmx_pkg::*;

    localparam int MIX_LATENCY    = 3;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int LONG_HOLD      = 64;
    localparam int RANDOM_PHASES  = 24;
    localparam int SLOTS_PER_PHASE = 20;

    localparam logic signed [SAMPLE_BITS-1:0] SMAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    localparam logic signed [SAMPLE_BITS-1:0] SMIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

    // Q16 gains
    localparam longint Q_MATRIX_SUR   = 14844;
    localparam longint Q_MATRIX_FRONT = 20998;
    localparam longint Q_MATRIX_CTR   = 14844;
    localparam longint Q_PLAIN_FRONT  = 27145;
    localparam longint Q_MONO         = 46341;
    localparam longint Q_CENTRE [4]   = '{19189, 16174, 13573, 16174};
    localparam longint Q_SURROUND [4] = '{19189, 13573, 0, 13573};

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] s0;
        logic signed [SAMPLE_BITS-1:0] s1;
        logic signed [SAMPLE_BITS-1:0] s2;
        logic signed [SAMPLE_BITS-1:0] s3;
        logic signed [SAMPLE_BITS-1:0] s4;
    } slot_t;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] left;
        logic signed [SAMPLE_BITS-1:0] right;
    } stereo_t;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  cfg_wr_en;
    logic [CFG_IDX_W-1:0]  cfg_addr;
    logic [CFG_DATA_W-1:0] cfg_wdata;

    dmx_in_if  slot_in ();
    dmx_out_if mix_out ();

    multichannel_to_stereo_downmix_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .slot_in   (slot_in),
        .mix_out   (mix_out),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    slot_t   pending_slots [$];
    stereo_t expected_mix [$];
    cfg_t    mix_cfg;

    int  src_idle_pct;
    int  sink_stall_pct;
    bit  hold_req;
    bit  slot_taken;
    int  mismatches;
    int  slots_mixed;
    int  pairs_checked;
    int  settings_run;
    int  idle_cycles;

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function automatic logic signed [SAMPLE_BITS-1:0] round_sat(longint acc);
        longint q;
        longint hi;
        longint lo;
        hi = (longint'(1) <<< (SAMPLE_BITS - 1)) - 1;
        lo = -hi - 1;
        // round half up, then clip
        q = (acc + 32768) >>> 16;
        if (q > hi)
            q = hi;
        if (q < lo)
            q = lo;
        return q[SAMPLE_BITS-1:0];
    endfunction

    function automatic stereo_t downmix_predict(slot_t slot);
        longint  s0, s1, s2, s3, s4;
        longint  cg, sg, sur, accl, accr;
        stereo_t pair;
        s0 = longint'(slot.s0);
        s1 = longint'(slot.s1);
        s2 = longint'(slot.s2);
        s3 = longint'(slot.s3);
        s4 = longint'(slot.s4);
        cg = Q_CENTRE[mix_cfg.center_code];
        sg = Q_SURROUND[mix_cfg.surround_code];
        accl = 0;
        accr = 0;
        if (mix_cfg.layout == LAYOUT_STEREO)
        begin
            pair.left  = slot.s0;
            pair.right = slot.s1;
            return pair;
        end
        if (mix_cfg.matrix_on)
        begin
            case (mix_cfg.layout)
                LAYOUT_3_2:
                begin
                    sur  = Q_MATRIX_SUR * s3 + Q_MATRIX_SUR * s4;
                    accl = -sur + Q_MATRIX_FRONT * s0 + Q_MATRIX_CTR * s1;
                    accr = sur + Q_MATRIX_FRONT * s2 + Q_MATRIX_CTR * s1;
                end
                LAYOUT_2_2:
                begin
                    sur  = Q_MATRIX_SUR * s2 + Q_MATRIX_SUR * s3;
                    accl = -sur + Q_MATRIX_FRONT * s0;
                    accr = sur + Q_MATRIX_FRONT * s1;
                end
                LAYOUT_3_1:
                begin
                    sur  = Q_MATRIX_SUR * s3;
                    accl = -sur + Q_MATRIX_FRONT * s0 + Q_MATRIX_CTR * s1;
                    accr = sur + Q_MATRIX_FRONT * s2 + Q_MATRIX_CTR * s1;
                end
                LAYOUT_2_1:
                begin
                    sur  = Q_MATRIX_SUR * s2;
                    accl = -sur + Q_MATRIX_FRONT * s0;
                    accr = sur + Q_MATRIX_FRONT * s1;
                end
                LAYOUT_3_0:
                begin
                    accl = Q_MATRIX_FRONT * s0 + Q_MATRIX_CTR * s1;
                    accr = Q_MATRIX_FRONT * s2 + Q_MATRIX_CTR * s1;
                end
                LAYOUT_MONO:
                begin
                    accl = Q_MONO * s0;
                    accr = accl;
                end
                default:
                begin
                    accl = Q_MONO * (mix_cfg.dual_pick ? s1 : s0);
                    accr = accl;
                end
            endcase
        end
        else
        begin
            case (mix_cfg.layout)
                LAYOUT_3_2:
                begin
                    accl = Q_PLAIN_FRONT * s0 + cg * s1 + sg * s3;
                    accr = Q_PLAIN_FRONT * s2 + cg * s1 + sg * s4;
                end
                LAYOUT_2_2:
                begin
                    accl = Q_PLAIN_FRONT * s0 + sg * s2;
                    accr = Q_PLAIN_FRONT * s1 + sg * s3;
                end
                LAYOUT_3_1:
                begin
                    accl = Q_PLAIN_FRONT * s0 + cg * s1 + sg * s3;
                    accr = Q_PLAIN_FRONT * s2 + cg * s1 + sg * s3;
                end
                LAYOUT_2_1:
                begin
                    accl = Q_PLAIN_FRONT * s0 + sg * s2;
                    accr = Q_PLAIN_FRONT * s1 + sg * s2;
                end
                LAYOUT_3_0:
                begin
                    accl = Q_PLAIN_FRONT * s0 + cg * s1;
                    accr = Q_PLAIN_FRONT * s2 + cg * s1;
                end
                LAYOUT_MONO:
                begin
                    accl = Q_MONO * s0;
                    accr = accl;
                end
                default:
                begin
                    accl = Q_MONO * (mix_cfg.dual_pick ? s1 : s0);
                    accr = accl;
                end
            endcase
        end
        pair.left  = round_sat(accl);
        pair.right = round_sat(accr);
        return pair;
    endfunction

    task automatic report(string msg);
        $display("%0t ns: %s", $time, msg);
        mismatches++;
    endtask

    // sender: new slot at the falling edge unless one is still waiting for its transfer
    always @(negedge clk)
    begin
        if (!rst_n)
            slot_in.valid <= 1'b0;
        else if (!(slot_in.valid && !slot_taken))
        begin
            if (pending_slots.size() != 0 && $urandom_range(0, 99) >= src_idle_pct)
            begin
                slot_in.valid        <= 1'b1;
                slot_in.sample_slot0 <= pending_slots[0].s0;
                slot_in.sample_slot1 <= pending_slots[0].s1;
                slot_in.sample_slot2 <= pending_slots[0].s2;
                slot_in.sample_slot3 <= pending_slots[0].s3;
                slot_in.sample_slot4 <= pending_slots[0].s4;
            end
            else
                slot_in.valid <= 1'b0;
        end
    end

    // receiver: random stalls, plus a long hold-off on request
    int hold_left = 0;
    always @(negedge clk)
    begin
        if (hold_req)
        begin
            hold_left = LONG_HOLD;
            hold_req  = 1'b0;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            mix_out.ready <= 1'b0;
        end
        else
            mix_out.ready <= ($urandom_range(0, 99) >= sink_stall_pct);
    end

    always @(posedge clk)
    begin
        slot_t   slot;
        stereo_t want;
        bit      moved;
        moved = 1'b0;
        slot_taken <= rst_n && slot_in.valid && slot_in.ready;
        if (rst_n && slot_in.valid && slot_in.ready)
        begin
            slot.s0 = slot_in.sample_slot0;
            slot.s1 = slot_in.sample_slot1;
            slot.s2 = slot_in.sample_slot2;
            slot.s3 = slot_in.sample_slot3;
            slot.s4 = slot_in.sample_slot4;
            void'(pending_slots.pop_front());
            expected_mix.push_back(downmix_predict(slot));
            slots_mixed++;
            moved = 1'b1;
        end
        if (rst_n && mix_out.valid && mix_out.ready)
        begin
            moved = 1'b1;
            if (expected_mix.size() == 0)
                report($sformatf("stereo pair %0d/%0d with none expected",
                                 mix_out.mix_left, mix_out.mix_right));
            else
            begin
                want = expected_mix.pop_front();
                pairs_checked++;
                if (mix_out.mix_left !== want.left)
                    report($sformatf("mix_left got %0d expected %0d",
                                     mix_out.mix_left, want.left));
                if (mix_out.mix_right !== want.right)
                    report($sformatf("mix_right got %0d expected %0d",
                                     mix_out.mix_right, want.right));
            end
        end
        idle_cycles = moved ? 0 : idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("timeout: no transfer for %0d cycles", WATCHDOG_LIMIT);
            $display("multichannel_to_stereo_downmix_unit: mismatch");
            $finish;
        end
    end

    task automatic write_reg(logic [CFG_IDX_W-1:0] addr, logic [CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= addr;
        cfg_wdata <= data;
        case (addr)
            CFG_CHANNEL_LAYOUT:      mix_cfg.layout        = layout_t'(data[2:0]);
            CFG_MATRIX_SURROUND_ON:  mix_cfg.matrix_on     = data[0];
            CFG_CENTER_LEVEL_CODE:   mix_cfg.center_code   = data[1:0];
            CFG_SURROUND_LEVEL_CODE: mix_cfg.surround_code = data[1:0];
            CFG_DUAL_MONO_PICK:      mix_cfg.dual_pick     = data[0];
            default: ;
        endcase
        @(negedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    // upper data bits are junk that the narrow registers must drop
    task automatic set_mix(layout_t layout, logic matrix, logic [1:0] ctr, logic [1:0] sur,
                           logic pick);
        write_reg(CFG_CHANNEL_LAYOUT, layout);
        write_reg(CFG_MATRIX_SURROUND_ON, {2'($urandom), matrix});
        write_reg(CFG_CENTER_LEVEL_CODE, {1'($urandom), ctr});
        write_reg(CFG_SURROUND_LEVEL_CODE, {1'($urandom), sur});
        write_reg(CFG_DUAL_MONO_PICK, {2'($urandom), pick});
        settings_run++;
    endtask

    task automatic queue_slot(logic signed [SAMPLE_BITS-1:0] a, logic signed [SAMPLE_BITS-1:0] b,
                              logic signed [SAMPLE_BITS-1:0] c, logic signed [SAMPLE_BITS-1:0] d,
                              logic signed [SAMPLE_BITS-1:0] e);
        slot_t slot;
        slot = '{a, b, c, d, e};
        pending_slots.push_back(slot);
    endtask

    task automatic drain();
        while (pending_slots.size() != 0 || expected_mix.size() != 0)
            @(posedge clk);
        repeat (MIX_LATENCY + 2) @(posedge clk);
    endtask

    function automatic logic signed [SAMPLE_BITS-1:0] rand_sample();
        case ($urandom_range(0, 7))
            0:       return SMAX;
            1:       return SMIN;
            2:       return SAMPLE_BITS'($signed($urandom_range(0, 512)) - 256);
            default: return SAMPLE_BITS'($urandom());
        endcase
    endfunction

    initial
    begin
        rst_n                = 1'b0;
        cfg_wr_en            = 1'b0;
        cfg_addr             = '0;
        cfg_wdata            = '0;
        slot_in.valid        = 1'b0;
        slot_in.sample_slot0 = '0;
        slot_in.sample_slot1 = '0;
        slot_in.sample_slot2 = '0;
        slot_in.sample_slot3 = '0;
        slot_in.sample_slot4 = '0;
        mix_out.ready        = 1'b0;
        src_idle_pct         = 0;
        sink_stall_pct       = 0;
        mix_cfg              = '{LAYOUT_STEREO, 1'b0, 2'd0, 2'd0, 1'b0};
        repeat (6) @(negedge clk);
        rst_n = 1'b1;

        // reset setting is stereo pass-through
        queue_slot(SMAX, SMIN, 0, 0, 0);
        queue_slot(SMIN, SMAX, -1, SMAX, SMIN);
        queue_slot(0, -1, 1, SMIN, SMAX);
        drain();
        settings_run++;

        // each layout but stereo in both plain and matrix mode, dual mono with both picks
        for (int l = 0; l < 8; l++)
        begin
            for (int m = 0; m < 2; m++)
            begin
                if (layout_t'(l) == LAYOUT_STEREO)
                    continue;
                set_mix(layout_t'(l), 1'(m), 2'(l), 2'(l + 2), 1'(m));
                if (m == 0)
                    queue_slot(SMAX, SMIN, SMAX, SMIN, SMAX);
                else
                    queue_slot(SMIN, SMAX, SMIN, SMAX, SMIN);
                drain();
            end
        end

        // both level codes at 3; writes past the last register must change nothing
        set_mix(LAYOUT_3_2, 1'b0, 2'd3, 2'd3, 1'b0);
        for (int a = int'(CFG_DUAL_MONO_PICK) + 1; a < 2 ** CFG_IDX_W; a++)
            write_reg(CFG_IDX_W'(a), '1);
        queue_slot(SMAX, SMAX, SMAX, SMAX, SMAX);
        queue_slot(SMIN, SMIN, SMIN, SMIN, SMIN);
        drain();

        for (int ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            set_mix(layout_t'($urandom_range(0, 7)), 1'($urandom), 2'($urandom),
                    2'($urandom), 1'($urandom));
            case (ph % 4)
                0:       begin src_idle_pct = 0;  sink_stall_pct = 0;  end
                1:       begin src_idle_pct = 47; sink_stall_pct = 0;  end
                2:       begin src_idle_pct = 0;  sink_stall_pct = 47; end
                default: begin src_idle_pct = 12; sink_stall_pct = 12; end
            endcase
            // output held off while input keeps coming, so the pipe backs up
            if (ph == 5)
            begin
                src_idle_pct   = 0;
                sink_stall_pct = 0;
                hold_req       = 1'b1;
            end
            repeat (SLOTS_PER_PHASE)
                queue_slot(rand_sample(), rand_sample(), rand_sample(), rand_sample(),
                           rand_sample());
            drain();
        end

        $display("%0d slots mixed under %0d register settings, %0d stereo pairs compared",
                 slots_mixed, settings_run, pairs_checked);
        $display("%0d mismatches", mismatches);
        if (mismatches == 0)
            $display("multichannel_to_stereo_downmix_unit: match");
        else
            $display("multichannel_to_stereo_downmix_unit: mismatch");
        $finish;
    end

endmodule

### multichannel_to_stereo_downmix_unit.f
rtl/dmx_pkg.sv
rtl/dmx_in_if.sv
rtl/dmx_out_if.sv
rtl/dmx_route.sv
rtl/dmx_lane.sv
rtl/dmx_merge.sv
rtl/multichannel_to_stereo_downmix_unit.sv
rtl/dmx_checker.sv
sim/tb.sv
